@@ design/thl_pkg.sv @@
// ----------------------------------------------------------------------------
// thl_pkg
// Shared widths, register map, reset values and the exp(-x) table builder
// for the thermal lag hotspot update block.
// ----------------------------------------------------------------------------
package thl_pkg;

  localparam int TempW  = 16;
  localparam int TauW   = 16;
  localparam int DtW    = 11;
  localparam int NumW   = DtW + 16;
  localparam int ExpW   = 17;
  localparam int FracW  = 20;

  localparam logic [DtW-1:0]   DtMaxMs      = 11'd2000;
  localparam logic [TauW-1:0]  TauDefaultMs = 16'd1000;

  localparam logic [TempW-1:0] TargetReset  = 16'd10400;
  localparam logic [TauW-1:0]  HeatTauReset = 16'd1000;
  localparam logic [TauW-1:0]  CoolTauReset = 16'd6000;

  localparam int DefSlots    = 16;
  localparam int DefExpDepth = 256;

  // register map, index = paddr[4:2]
  localparam logic [2:0] RegTarget  = 3'd0;
  localparam logic [2:0] RegHeatTau = 3'd1;
  localparam logic [2:0] RegCoolTau = 3'd2;
  localparam logic [2:0] RegHotEn   = 3'd3;
  localparam logic [2:0] RegGate    = 3'd4;

  // floor(v / k) for the Taylor term index k, each a constant divisor
  function automatic logic [63:0] div_term(input logic [63:0] v, input int k);
    logic [63:0] q;
    case (k)
      2:  q = v / 2;
      3:  q = v / 3;
      4:  q = v / 4;
      5:  q = v / 5;
      6:  q = v / 6;
      7:  q = v / 7;
      8:  q = v / 8;
      9:  q = v / 9;
      10: q = v / 10;
      11: q = v / 11;
      12: q = v / 12;
      13: q = v / 13;
      14: q = v / 14;
      15: q = v / 15;
      16: q = v / 16;
      17: q = v / 17;
      18: q = v / 18;
      19: q = v / 19;
      20: q = v / 20;
      21: q = v / 21;
      22: q = v / 22;
      23: q = v / 23;
      24: q = v / 24;
      default: q = v;
    endcase
    return q;
  endfunction

  // exp(-16 t) in Q1.16, t in Q30: Taylor sum of exp(-t), squared four times
  function automatic logic [ExpW-1:0] exp_neg_q16(input logic [63:0] t);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    logic [63:0] r;
    pos  = 64'd1 << 30;
    neg  = 64'd0;
    term = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) begin
      term = div_term((term * t) >> 30, k);
      if (k % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    r = (pos > neg) ? pos - neg : 64'd0;
    if (r > (64'd1 << 30)) r = 64'd1 << 30;
    for (int s = 0; s < 4; s++) begin
      r = (r * r + (64'd1 << 29)) >> 30;
    end
    r = (r + (64'd1 << 13)) >> 14;
    return r[ExpW-1:0];
  endfunction

endpackage

@@ design/thl_div.sv @@
// ----------------------------------------------------------------------------
// thl_div
// Restoring divider, one quotient bit per cycle: quo = floor(num / den).
// ----------------------------------------------------------------------------
module thl_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [thl_pkg::NumW-1:0]   num_i,
  input  logic [thl_pkg::TauW-1:0]   den_i,
  output logic                       done_o,
  output logic [thl_pkg::NumW-1:0]   quo_o
);

  localparam int CntW = $clog2(thl_pkg::NumW + 1);

  logic [CntW-1:0]             cnt_q;
  logic                        run_q;
  logic                        done_q;
  logic [thl_pkg::TauW-1:0]    den_q;
  logic [thl_pkg::TauW-1:0]    rem_q;
  logic [thl_pkg::NumW-1:0]    quo_q;
  logic [thl_pkg::TauW:0]      shift;
  logic                        fits;

  // trial subtract of the shifted remainder
  assign shift = {rem_q, quo_q[thl_pkg::NumW-1]};
  assign fits  = shift >= {1'b0, den_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(thl_pkg::NumW);
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (run_q) begin
      rem_q <= fits ? thl_pkg::TauW'(shift - {1'b0, den_q}) : shift[thl_pkg::TauW-1:0];
      quo_q <= {quo_q[thl_pkg::NumW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ design/thl_store.sv @@
// ----------------------------------------------------------------------------
// thl_store
// Per-slot temperature memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module thl_store #(
  parameter int SLOTS = thl_pkg::DefSlots,
  parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [thl_pkg::TempW-1:0]   rd_data_o,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [thl_pkg::TempW-1:0]   wr_data_i
);

  logic [thl_pkg::TempW-1:0] mem [SLOTS];
  logic [thl_pkg::TempW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

@@ design/thermal_lag_hotspot_update.sv @@
// ----------------------------------------------------------------------------
// thermal_lag_hotspot_update
// Per-slot first order thermal lag with hotspot enable.
// ----------------------------------------------------------------------------
// The result strobe is high in the same cycle in which busy falls, so the next
// request can be accepted at the edge that ends it. The bit-serial divider for
// dt/tau overlaps the memory read, and the table lookup, the interpolation and
// the blend follow it in turn. The result is shown for one cycle on
// result_valid_o and cannot be held off by the receiver. A clear request takes
// effect at once, gives no result and keeps busy low.
module thermal_lag_hotspot_update #(
  parameter int SLOTS           = thl_pkg::DefSlots,
  parameter int EXP_TABLE_DEPTH = thl_pkg::DefExpDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request
  input  logic         start,
  output logic         busy,
  input  logic         kind_i,
  input  logic [3:0]   slot_i,
  input  logic         engine_on_i,
  input  logic signed [15:0] elapsed_ms_i,
  input  logic [15:0]  ambient_temp_i,
  // result
  output logic         result_valid_o,
  output logic [3:0]   slot_echo_o,
  output logic [15:0]  current_temp_o,
  output logic         hotspot_on_o,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IW  = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PW  = thl_pkg::NumW + IW;
  localparam int TW  = thl_pkg::TempW;
  localparam int EW  = thl_pkg::ExpW;
  localparam int FW  = thl_pkg::FracW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_DIV, ST_MIX, ST_BLEND
  } state_e;

  state_e state_q;

  // configuration registers
  logic [TW-1:0]            target_q;
  logic [thl_pkg::TauW-1:0] heat_tau_q;
  logic [thl_pkg::TauW-1:0] cool_tau_q;
  logic                     hot_en_q;
  logic                     gate_q;

  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= thl_pkg::TargetReset;
      heat_tau_q <= thl_pkg::HeatTauReset;
      cool_tau_q <= thl_pkg::CoolTauReset;
      hot_en_q   <= 1'b1;
      gate_q     <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        thl_pkg::RegTarget:  target_q   <= pwdata[TW-1:0];
        thl_pkg::RegHeatTau: heat_tau_q <= pwdata[thl_pkg::TauW-1:0];
        thl_pkg::RegCoolTau: cool_tau_q <= pwdata[thl_pkg::TauW-1:0];
        thl_pkg::RegHotEn:   hot_en_q   <= pwdata[0];
        thl_pkg::RegGate:    gate_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      thl_pkg::RegTarget:  prdata = {16'b0, target_q};
      thl_pkg::RegHeatTau: prdata = {16'b0, heat_tau_q};
      thl_pkg::RegCoolTau: prdata = {16'b0, cool_tau_q};
      thl_pkg::RegHotEn:   prdata = {31'b0, hot_en_q};
      thl_pkg::RegGate:    prdata = {31'b0, gate_q};
      default:             prdata = '0;
    endcase
  end

  // exp(-16 i / depth) table, built at elaboration
  logic [EW-1:0] exp_tab [EXP_TABLE_DEPTH + 1];

  for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [63:0] TArg = (64'(g) << 30) / EXP_TABLE_DEPTH;
    assign exp_tab[g] = thl_pkg::exp_neg_q16(TArg);
  end

  // request decode
  logic accept, upd, in_range;
  logic [thl_pkg::DtW-1:0]  dt;
  logic [thl_pkg::TauW-1:0] tau_sel, tau;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start & ~busy;
  assign in_range = {28'b0, slot_i} < 32'(SLOTS);
  assign upd      = accept & ~kind_i & in_range;

  always_comb begin
    if (elapsed_ms_i < 0) dt = '0;
    else if (elapsed_ms_i > 16'sd2000) dt = thl_pkg::DtMaxMs;
    else dt = elapsed_ms_i[thl_pkg::DtW-1:0];
    tau_sel = engine_on_i ? heat_tau_q : cool_tau_q;
    tau     = (tau_sel == '0) ? thl_pkg::TauDefaultMs : tau_sel;
  end

  // divider for x = dt * 2^16 / tau
  logic                     div_done;
  logic [thl_pkg::NumW-1:0] div_quo;

  thl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (upd),
    .num_i   ({dt, 16'b0}),
    .den_i   (tau),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // temperature store
  logic [AW-1:0]   slot_q;
  logic [TW-1:0]   rd_data;
  logic            wr_en;
  logic [TW-1:0]   nxt;

  thl_store #(.SLOTS(SLOTS), .AW(AW)) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (upd),
    .rd_addr_i (AW'(slot_i)),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (slot_q),
    .wr_data_i (nxt)
  );

  assign wr_en = (state_q == ST_BLEND);

  // table index and fraction from x
  logic [PW-1:0]    p;
  logic [PW-FW-1:0] idx_full;
  logic             sat;
  logic [IW-1:0]    idx;

  assign p        = PW'(div_quo) * PW'(EXP_TABLE_DEPTH);
  assign idx_full = p[PW-1:FW];
  assign sat      = idx_full >= (PW-FW)'(EXP_TABLE_DEPTH);
  assign idx      = sat ? '0 : IW'(idx_full);

  // interpolation
  logic [EW-1:0]    e0_q, e1_q;
  logic [FW-1:0]    f_q;
  logic             sat_q;
  logic [EW-1:0]    drop;
  logic [EW+FW-1:0] prod;
  logic [EW-1:0]    corr, e_val, alpha_d;
  logic [EW-1:0]    alpha_q;

  assign drop    = (e0_q >= e1_q) ? e0_q - e1_q : '0;
  assign prod    = (EW+FW)'(drop) * (EW+FW)'(f_q);
  assign corr    = EW'((prod + (EW+FW)'(1 << 19)) >> FW);
  assign e_val   = e0_q - corr;
  assign alpha_d = sat_q ? EW'(1 << 16) : EW'(1 << 16) - e_val;

  // blend toward the desired temperature
  logic [TW-1:0]    cur_q, want_q, amb_q;
  logic             eng_q, hot_q;
  logic [3:0]       slot_in_q;
  logic [SLOTS-1:0] valid_q;
  logic             up;
  logic [TW-1:0]    mag_in;
  logic [TW+EW-1:0] mprod;
  logic [TW-1:0]    mag;

  assign up     = want_q >= cur_q;
  assign mag_in = up ? want_q - cur_q : cur_q - want_q;
  assign mprod  = (TW+EW)'(mag_in) * (TW+EW)'(alpha_q);
  assign mag    = TW'((mprod + (TW+EW)'(1 << 15)) >> 16);
  assign nxt    = up ? cur_q + mag : cur_q - mag;

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      valid_q        <= '0;
      result_valid_o <= 1'b0;
      slot_echo_o    <= '0;
      current_temp_o <= '0;
      hotspot_on_o   <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept && kind_i) valid_q <= '0;
          else if (upd) state_q <= ST_FETCH;
        end
        ST_FETCH: state_q <= ST_DIV;
        ST_DIV:   if (div_done) state_q <= ST_MIX;
        ST_MIX:   state_q <= ST_BLEND;
        ST_BLEND: begin
          valid_q[slot_q] <= 1'b1;
          result_valid_o  <= 1'b1;
          slot_echo_o     <= slot_in_q;
          current_temp_o  <= nxt;
          hotspot_on_o    <= hot_q & eng_q;
          state_q         <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (upd) begin
      slot_q    <= AW'(slot_i);
      slot_in_q <= slot_i;
      eng_q     <= engine_on_i;
      amb_q     <= ambient_temp_i;
      want_q    <= engine_on_i ? target_q : ambient_temp_i;
      hot_q     <= hot_en_q & gate_q & engine_on_i;
    end
    if (state_q == ST_FETCH) cur_q <= valid_q[slot_q] ? rd_data : amb_q;
    if (state_q == ST_DIV && div_done) begin
      e0_q  <= exp_tab[idx];
      e1_q  <= exp_tab[idx + IW'(1)];
      f_q   <= p[FW-1:0];
      sat_q <= sat;
    end
    if (state_q == ST_MIX) alpha_q <= alpha_d;
  end

endmodule
